// File: rtl/decimated_sliding_min_max_defines.svh
// Assertion macros shared by the decimated sliding min/max RTL.
// Used by dsmm_deque and decimated_sliding_min_max; expects clk and rst_n in scope.
`ifndef DECIMATED_SLIDING_MIN_MAX_DEFINES_SVH
`define DECIMATED_SLIDING_MIN_MAX_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define SMM_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset.
`define SMM_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/dsmm_pkg.sv
// Package for the decimated sliding min/max block: widths, register indexes,
// window limits, state enums and the command struct. No dependencies.
package dsmm_pkg;

    localparam int IDX_W     = 17;
    localparam int WIN_W     = 16;
    localparam int DECIM_W   = 8;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_DECIM  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW = 1'b1;

    localparam logic [DECIM_W-1:0]   DECIM_RESET = 8'd44;
    localparam logic [WIN_W-1:0]     WIN_RESET   = 16'd5000;
    localparam logic [IDX_W-1:0]     WIN_LOW     = 17'd100;
    localparam logic [IDX_W-1:0]     WIN_HIGH    = 17'd50000;

    typedef enum logic [0:0] {
        T_IDLE,
        T_WAIT
    } top_state_t;

    typedef enum logic [2:0] {
        DQ_IDLE,
        DQ_BACK,
        DQ_PUSH,
        DQ_FRONT,
        DQ_HEAD
    } dq_state_t;

    // Command from the top level to both deques.
    typedef struct packed {
        logic             start;
        logic             clear;
        logic [IDX_W-1:0] idx;
        logic [WIN_W-1:0] win;
    } dsmm_cmd_t;

endpackage

// File: rtl/dsmm_if.sv
// Valid/ready channel interfaces for the decimated sliding min/max block.
// Sample channel in, peak channel out; no package dependency.
interface dsmm_in_if #(parameter int SAMPLE_BITS = 16);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] in_sample;

    modport source (output valid, output in_sample, input ready);
    modport sink   (input valid, input in_sample, output ready);
endinterface

interface dsmm_out_if #(parameter int SAMPLE_BITS = 16);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] peak_min;
    logic signed [SAMPLE_BITS-1:0] peak_max;
    logic                          peak_updated;

    modport source (output valid, output peak_min, output peak_max, output peak_updated,
                    input ready);
    modport sink   (input valid, input peak_min, input peak_max, input peak_updated,
                    output ready);
endinterface

// File: rtl/dsmm_deque.sv
// Monotonic deque of (index, value) pairs held in one synchronous RAM.
// Depends on dsmm_pkg and decimated_sliding_min_max_defines.svh.
`include "decimated_sliding_min_max_defines.svh"

module dsmm_deque #(
    parameter int MAX_WINDOW  = 65536,
    parameter int SAMPLE_BITS = 16,
    parameter bit WANT_MAX    = 1'b0
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  dsmm_pkg::dsmm_cmd_t           cmd,
    input  logic signed [SAMPLE_BITS-1:0] sample,
    output logic                          done,
    output logic signed [SAMPLE_BITS-1:0] front_val
);
    import dsmm_pkg::*;

    localparam int AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int CW = $clog2(MAX_WINDOW + 1);
    localparam int EW = IDX_W + SAMPLE_BITS;
    localparam logic [AW-1:0] LAST_PTR = AW'(MAX_WINDOW - 1);
    localparam logic [CW-1:0] MAX_COUNT = CW'(MAX_WINDOW);

    dq_state_t state_reg, state_next;
    logic [AW-1:0] head_reg, head_next;
    logic [AW-1:0] tail_reg, tail_next;
    logic [CW-1:0] count_reg, count_next;

    logic [EW-1:0] mem [MAX_WINDOW];
    logic [EW-1:0] rd_data_reg;
    logic [AW-1:0] rd_addr;
    logic          wr_en;

    logic [AW-1:0] tail_dec, tail_dec2, head_inc;
    logic signed [SAMPLE_BITS-1:0] rd_val;
    logic [IDX_W-1:0] rd_idx, age;
    logic drop, expire;

    function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
        return (p == LAST_PTR) ? '0 : p + AW'(1);
    endfunction

    function automatic logic [AW-1:0] ptr_dec(input logic [AW-1:0] p);
        return (p == '0) ? LAST_PTR : p - AW'(1);
    endfunction

    assign tail_dec  = ptr_dec(tail_reg);
    assign tail_dec2 = ptr_dec(tail_dec);
    assign head_inc  = ptr_inc(head_reg);
    assign rd_val    = $signed(rd_data_reg[SAMPLE_BITS-1:0]);
    assign rd_idx    = rd_data_reg[EW-1:SAMPLE_BITS];
    assign age       = cmd.idx - rd_idx;
    assign drop      = WANT_MAX ? (sample >= rd_val) : (sample <= rd_val);
    // old head is the entry just pushed when count is one: never stale
    assign expire    = (count_reg > CW'(1)) && (age >= {1'b0, cmd.win});

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            DQ_IDLE:
            begin
                if (cmd.start)
                begin
                    state_next = (count_reg == '0) ? DQ_PUSH : DQ_BACK;
                end
            end
            DQ_BACK:
            begin
                if (!(drop && (count_reg > CW'(1))))
                begin
                    state_next = DQ_PUSH;
                end
            end
            DQ_PUSH:  state_next = DQ_FRONT;
            DQ_FRONT: state_next = expire ? DQ_HEAD : DQ_IDLE;
            DQ_HEAD:  state_next = DQ_IDLE;
            default:  state_next = DQ_IDLE;
        endcase
        if (cmd.clear)
        begin
            state_next = DQ_IDLE;
        end
    end

    // pointers
    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        case (state_reg)
            DQ_BACK:
            begin
                if (drop)
                begin
                    tail_next  = tail_dec;
                    count_next = count_reg - CW'(1);
                end
            end
            DQ_PUSH:
            begin
                tail_next  = ptr_inc(tail_reg);
                count_next = count_reg + CW'(1);
            end
            DQ_FRONT:
            begin
                if (expire)
                begin
                    head_next  = head_inc;
                    count_next = count_reg - CW'(1);
                end
            end
            default:
            begin
                head_next = head_reg;
            end
        endcase
        if (cmd.clear)
        begin
            head_next  = '0;
            tail_next  = '0;
            count_next = '0;
        end
    end

    // outputs and RAM controls
    always_comb
    begin
        done      = 1'b0;
        front_val = rd_val;
        wr_en     = 1'b0;
        rd_addr   = head_reg;
        case (state_reg)
            DQ_IDLE:  rd_addr = tail_dec;
            DQ_BACK:  rd_addr = drop ? tail_dec2 : tail_dec;
            DQ_PUSH:
            begin
                wr_en   = 1'b1;
                rd_addr = head_reg;
            end
            DQ_FRONT:
            begin
                rd_addr   = head_inc;
                done      = !expire;
                front_val = (count_reg == CW'(1)) ? sample : rd_val;
            end
            DQ_HEAD:  done = 1'b1;
            default:  done = 1'b0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[tail_reg] <= {cmd.idx, sample};
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= DQ_IDLE;
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    `SMM_ASSERT_IMP(a_count_cap, 1'b1, count_reg <= MAX_COUNT, "deque count over capacity")
    `SMM_ASSERT_IMP(a_empty_ptrs, count_reg == '0, head_reg == tail_reg, "empty deque pointers")
    `SMM_ASSERT_NXT(a_done_idle, done && !cmd.clear, state_reg == DQ_IDLE, "deque not idle")

endmodule

// File: rtl/decimated_sliding_min_max.sv
// Top level of the decimated sliding-window min/max detector.
// Depends on dsmm_pkg, dsmm_if, dsmm_deque and decimated_sliding_min_max_defines.svh.
//
// Usage:
//   samples: valid/ready sink, one signed sample per transfer.
//   peaks:   valid/ready source, exactly one result per accepted sample:
//            held window min and max, plus peak_updated when the sample was kept.
//   cfg:     write port; index 0 decimation factor, index 1 window length.
//            Writing the window length empties both deques and zeroes the peaks.
//            Write only while no sample is in flight.
// Flow:
//   A sample that is not kept gives its result in the cycle after the transfer.
//   A kept sample gives its result once both deques are done: each deque compares
//   back entries (each pop, and the compare that stops on a surviving entry),
//   pushes the sample, checks its front entry and pops it when it has left the
//   window; each deque step is one registered read of its RAM.
//   One sample is in flight at a time; the next one is taken in the cycle its
//   result transfers, so a stalled receiver holds off the sample channel.
// Reset: peaks read 0, decimation factor 44, window length 5000, deques empty.
`include "decimated_sliding_min_max_defines.svh"

module decimated_sliding_min_max #(
    parameter int MAX_WINDOW  = 65536,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    dsmm_in_if.sink                          samples,
    dsmm_out_if.source                       peaks,
    input  logic                             cfg_we,
    input  logic [dsmm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [dsmm_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import dsmm_pkg::*;

    localparam logic [IDX_W-1:0] WIN_CAP = IDX_W'(MAX_WINDOW - 1);

    top_state_t state_reg, state_next;
    logic [DECIM_W-1:0] factor_reg, factor_next;
    logic [WIN_W-1:0]   win_len_reg, win_len_next;
    logic [DECIM_W-1:0] decim_reg, decim_next;
    logic [IDX_W-1:0]   kept_idx_reg, kept_idx_next;
    logic signed [SAMPLE_BITS-1:0] samp_reg;
    logic signed [SAMPLE_BITS-1:0] held_min_reg, held_min_next;
    logic signed [SAMPLE_BITS-1:0] held_max_reg, held_max_next;
    logic start_reg, start_next;
    logic min_done_reg, min_done_next;
    logic max_done_reg, max_done_next;
    logic out_valid_reg, out_valid_next;
    logic updated_reg, updated_next;

    logic accept, keep, finish, clear;
    logic [DECIM_W-1:0] factor_eff, decim_inc;
    logic [IDX_W-1:0] win_wide;
    dsmm_cmd_t cmd;
    logic min_done, max_done;
    logic signed [SAMPLE_BITS-1:0] min_front, max_front;

    assign samples.ready = (state_reg == T_IDLE) && (!out_valid_reg || peaks.ready);
    assign accept        = samples.valid && samples.ready;
    assign factor_eff    = (factor_reg == '0) ? DECIM_W'(1) : factor_reg;
    assign decim_inc     = decim_reg + DECIM_W'(1);
    assign keep          = decim_inc >= factor_eff;
    assign clear         = cfg_we && (cfg_index == CFG_WINDOW);

    assign min_done_next = (min_done_reg || min_done) && !finish;
    assign max_done_next = (max_done_reg || max_done) && !finish;
    assign finish        = (state_reg == T_WAIT) && (min_done_reg || min_done)
                           && (max_done_reg || max_done);

    // effective window: clamp to legal range, then to one below the RAM depth
    always_comb
    begin
        if ({1'b0, win_len_reg} < WIN_LOW)
        begin
            win_wide = WIN_LOW;
        end
        else if ({1'b0, win_len_reg} > WIN_HIGH)
        begin
            win_wide = WIN_HIGH;
        end
        else
        begin
            win_wide = {1'b0, win_len_reg};
        end
        if (win_wide > WIN_CAP)
        begin
            win_wide = WIN_CAP;
        end
    end

    assign cmd.start = start_reg;
    assign cmd.clear = clear;
    assign cmd.idx   = kept_idx_reg;
    assign cmd.win   = win_wide[WIN_W-1:0];

    dsmm_deque #(
        .MAX_WINDOW  (MAX_WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS),
        .WANT_MAX    (1'b0)
    ) u_min (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sample    (samp_reg),
        .done      (min_done),
        .front_val (min_front)
    );

    dsmm_deque #(
        .MAX_WINDOW  (MAX_WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS),
        .WANT_MAX    (1'b1)
    ) u_max (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sample    (samp_reg),
        .done      (max_done),
        .front_val (max_front)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            T_IDLE:  state_next = (accept && keep) ? T_WAIT : T_IDLE;
            T_WAIT:  state_next = finish ? T_IDLE : T_WAIT;
            default: state_next = T_IDLE;
        endcase
    end

    // datapath and output register
    always_comb
    begin
        factor_next    = factor_reg;
        win_len_next   = win_len_reg;
        decim_next     = decim_reg;
        kept_idx_next  = kept_idx_reg;
        held_min_next  = held_min_reg;
        held_max_next  = held_max_reg;
        start_next     = 1'b0;
        updated_next   = updated_reg;
        out_valid_next = out_valid_reg && !peaks.ready;

        if (accept)
        begin
            if (keep)
            begin
                decim_next    = '0;
                kept_idx_next = kept_idx_reg + IDX_W'(1);
                start_next    = 1'b1;
            end
            else
            begin
                decim_next     = decim_inc;
                updated_next   = 1'b0;
                out_valid_next = 1'b1;
            end
        end

        if (min_done)
        begin
            held_min_next = min_front;
        end
        if (max_done)
        begin
            held_max_next = max_front;
        end
        if (finish)
        begin
            updated_next   = 1'b1;
            out_valid_next = 1'b1;
        end

        if (cfg_we)
        begin
            case (cfg_index)
                CFG_DECIM:  factor_next = cfg_data[DECIM_W-1:0];
                CFG_WINDOW:
                begin
                    win_len_next  = cfg_data[WIN_W-1:0];
                    kept_idx_next = '1;
                    held_min_next = '0;
                    held_max_next = '0;
                end
                default:    factor_next = factor_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            samp_reg <= samples.in_sample;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= T_IDLE;
            factor_reg    <= DECIM_RESET;
            win_len_reg   <= WIN_RESET;
            decim_reg     <= '0;
            kept_idx_reg  <= '1;
            held_min_reg  <= '0;
            held_max_reg  <= '0;
            start_reg     <= 1'b0;
            min_done_reg  <= 1'b0;
            max_done_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            updated_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            factor_reg    <= factor_next;
            win_len_reg   <= win_len_next;
            decim_reg     <= decim_next;
            kept_idx_reg  <= kept_idx_next;
            held_min_reg  <= held_min_next;
            held_max_reg  <= held_max_next;
            start_reg     <= start_next;
            min_done_reg  <= min_done_next;
            max_done_reg  <= max_done_next;
            out_valid_reg <= out_valid_next;
            updated_reg   <= updated_next;
        end
    end

    assign peaks.valid        = out_valid_reg;
    assign peaks.peak_min     = held_min_reg;
    assign peaks.peak_max     = held_max_reg;
    assign peaks.peak_updated = updated_reg;

    `SMM_ASSERT_IMP(a_busy_no_ready, state_reg == T_WAIT, !samples.ready, "ready while busy")
    `SMM_ASSERT_IMP(a_idle_no_flags, state_reg == T_IDLE, !min_done_reg && !max_done_reg,
        "stale done flag")
    `SMM_ASSERT_NXT(a_kept_starts, accept && keep, start_reg && (state_reg == T_WAIT),
        "kept sample did not start deques")
    `SMM_ASSERT_NXT(a_finish_out, finish, peaks.valid && peaks.peak_updated,
        "kept result not presented")

endmodule

// File: verif/decimated_sliding_min_max_test.sv
// Self-checking testbench for decimated_sliding_min_max: directed table, random phases
// and a run with no idling, each result checked against a local min/max deque model or a typed result.
// Depends on dsmm_pkg, dsmm_if and the RTL of the block.
module decimated_sliding_min_max_test;
    import dsmm_pkg::*;

    localparam int SAMPLE_BITS    = 16;
    localparam int MIN_TRACK      = 0;
    localparam int MAX_TRACK      = 1;
    localparam int QUIET_LIMIT    = 50000;
    localparam int STEADY_ITEMS   = 150;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] peak_min;
        logic signed [SAMPLE_BITS-1:0] peak_max;
        logic                          peak_updated;
    } peaks_t;

    typedef struct packed {
        logic [IDX_W-1:0]              idx;
        logic signed [SAMPLE_BITS-1:0] val;
    } entry_t;

    typedef enum logic [0:0] {
        ROW_SAMPLE,
        ROW_WRITE
    } row_kind_e;

    typedef struct packed {
        row_kind_e                     kind;
        logic [CFG_IDX_W-1:0]          reg_index;
        logic [CFG_DATA_W-1:0]         data;
        logic signed [SAMPLE_BITS-1:0] sample;
        logic                          pinned;
        peaks_t                        want;
    } row_t;

    typedef enum logic [2:0] {
        STY_NOISE,
        STY_NARROW,
        STY_RAMP_UP,
        STY_RAMP_DOWN,
        STY_EXTREME
    } sample_style_e;

    // Typed results only where they are obvious: before the first kept sample,
    // the first extremes, and the first sample after a history clear.
    localparam row_t DIRECTED [0:23] = '{
        '{ROW_SAMPLE, CFG_DECIM,  16'h0000,  16'sh7FFF, 1'b1, '{16'sh0000, 16'sh0000, 1'b0}},
        '{ROW_SAMPLE, CFG_DECIM,  16'h0000,  16'sh8000, 1'b1, '{16'sh0000, 16'sh0000, 1'b0}},
        '{ROW_SAMPLE, CFG_DECIM,  16'h0000,  16'sh5555, 1'b1, '{16'sh0000, 16'sh0000, 1'b0}},
        '{ROW_WRITE,  CFG_DECIM,  16'd1,     16'sh0000, 1'b0, '0},
        '{ROW_SAMPLE, CFG_DECIM,  16'h0000,  16'sh8000, 1'b1, '{16'sh8000, 16'sh8000, 1'b1}},
        '{ROW_SAMPLE, CFG_DECIM,  16'h0000,  16'sh7FFF, 1'b1, '{16'sh8000, 16'sh7FFF, 1'b1}},
        '{ROW_SAMPLE, CFG_DECIM,  16'h0000,  16'sh0000, 1'b0, '0},
        '{ROW_SAMPLE, CFG_DECIM,  16'h0000,  16'sh0000, 1'b0, '0},
        '{ROW_SAMPLE, CFG_DECIM,  16'h0000,  16'shFFFF, 1'b0, '0},
        '{ROW_WRITE,  CFG_WINDOW, 16'd0,     16'sh0000, 1'b0, '0},
        '{ROW_SAMPLE, CFG_DECIM,  16'h0000,  16'sh0001, 1'b1, '{16'sh0001, 16'sh0001, 1'b1}},
        '{ROW_SAMPLE, CFG_DECIM,  16'h0000,  16'sh0001, 1'b0, '0},
        '{ROW_WRITE,  CFG_DECIM,  16'd0,     16'sh0000, 1'b0, '0},
        '{ROW_SAMPLE, CFG_DECIM,  16'h0000,  16'sh8000, 1'b0, '0},
        '{ROW_SAMPLE, CFG_DECIM,  16'h0000,  16'sh7FFF, 1'b0, '0},
        '{ROW_WRITE,  CFG_DECIM,  16'hA502,  16'sh0000, 1'b0, '0},
        '{ROW_SAMPLE, CFG_DECIM,  16'h0000,  16'sh0064, 1'b0, '0},
        '{ROW_SAMPLE, CFG_DECIM,  16'h0000,  16'sh00C8, 1'b0, '0},
        '{ROW_WRITE,  CFG_WINDOW, 16'hFFFF,  16'sh0000, 1'b0, '0},
        '{ROW_SAMPLE, CFG_DECIM,  16'h0000,  16'shFFFB, 1'b0, '0},
        '{ROW_SAMPLE, CFG_DECIM,  16'h0000,  16'sh0007, 1'b0, '0},
        '{ROW_WRITE,  CFG_DECIM,  16'd255,   16'sh0000, 1'b0, '0},
        '{ROW_WRITE,  CFG_WINDOW, 16'd50000, 16'sh0000, 1'b0, '0},
        '{ROW_SAMPLE, CFG_DECIM,  16'h0000,  16'sh3039, 1'b0, '0}
    };

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    dsmm_in_if  #(.SAMPLE_BITS(SAMPLE_BITS)) in_ch ();
    dsmm_out_if #(.SAMPLE_BITS(SAMPLE_BITS)) out_ch ();

    decimated_sliding_min_max #(
        .MAX_WINDOW  (65536),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .samples   (in_ch),
        .peaks     (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Local copy of the block state
    logic [DECIM_W-1:0]            decim_factor = DECIM_RESET;
    logic [WIN_W-1:0]              window_len   = WIN_RESET;
    logic [DECIM_W-1:0]            decim_count  = '0;
    logic [IDX_W-1:0]              kept_index   = '1;
    logic signed [SAMPLE_BITS-1:0] held_min     = '0;
    logic signed [SAMPLE_BITS-1:0] held_max     = '0;
    entry_t                        track_q [2][$];

    peaks_t      expected_peaks [$];
    logic        pin_active = 1'b0;
    peaks_t      pin_peaks  = '0;
    bit          gaps_on    = 1'b1;
    int unsigned quiet_cycles = 0;
    int unsigned mismatches   = 0;
    int unsigned samples_sent = 0;
    int unsigned kept_total   = 0;
    int unsigned writes_done  = 0;
    int unsigned results_seen = 0;

    sample_style_e style      = STY_NOISE;
    int unsigned   style_left = 0;
    logic [15:0]   level      = '0;

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic peaks_t predict_peaks(input logic signed [SAMPLE_BITS-1:0] s);
        logic [DECIM_W-1:0] factor;
        logic [IDX_W-1:0]   age;
        logic [IDX_W-1:0]   win;
        bit                 drop;
        entry_t             fresh;
        peaks_t             p;
        factor = (decim_factor == '0) ? 8'd1 : decim_factor;
        decim_count = decim_count + 8'd1;
        p.peak_updated = 1'b0;
        if (decim_count >= factor)
        begin
            win = {1'b0, window_len};
            if (win < WIN_LOW)
                win = WIN_LOW;
            if (win > WIN_HIGH)
                win = WIN_HIGH;
            decim_count = '0;
            kept_index = kept_index + IDX_W'(1);
            fresh.idx = kept_index;
            fresh.val = s;
            for (int k = MIN_TRACK; k <= MAX_TRACK; k++)
            begin
                // equal back entries are replaced in both deques
                while (track_q[k].size() > 0)
                begin
                    if (k == MAX_TRACK)
                        drop = (s >= track_q[k][$].val);
                    else
                        drop = (s <= track_q[k][$].val);
                    if (!drop)
                        break;
                    track_q[k].delete(track_q[k].size() - 1);
                end
                track_q[k].insert(track_q[k].size(), fresh);
                while (track_q[k].size() > 0)
                begin
                    age = kept_index - track_q[k][0].idx;  // modulo 2^17
                    if (age < win)
                        break;
                    track_q[k].delete(0);
                end
            end
            held_min = track_q[MIN_TRACK][0].val;
            held_max = track_q[MAX_TRACK][0].val;
            kept_total++;
            p.peak_updated = 1'b1;
        end
        p.peak_min = held_min;
        p.peak_max = held_max;
        return p;
    endfunction

    function automatic logic signed [SAMPLE_BITS-1:0] next_sample();
        if (style_left == 0)
        begin
            style      = sample_style_e'($urandom_range(0, 4));
            style_left = $urandom_range(1, 40);
            level      = 16'($urandom);
        end
        style_left--;
        case (style)
            STY_NARROW:    return $signed(level + 16'($urandom_range(0, 3)));
            STY_RAMP_UP:
            begin
                level = level + 16'($urandom_range(1, 300));
                return $signed(level);
            end
            STY_RAMP_DOWN:
            begin
                level = level - 16'($urandom_range(1, 300));
                return $signed(level);
            end
            STY_EXTREME:   return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
            default:       return $signed(16'($urandom));
        endcase
    endfunction

    task automatic report_mismatch(input string msg);
        mismatches++;
        $display("ERROR @%0t: %s", $realtime, msg);
    endtask

    // Transfer monitor: keeps the local model in step and checks every result.
    always @(posedge clk)
    begin
        peaks_t want;
        bit     busy;
        if (rst_n)
        begin
            busy = cfg_we;
            if (cfg_we)
            begin
                writes_done++;
                case (cfg_index)
                    CFG_DECIM:  decim_factor = cfg_data[DECIM_W-1:0];
                    CFG_WINDOW:
                    begin
                        window_len = cfg_data;
                        kept_index = '1;
                        track_q[MIN_TRACK].delete();
                        track_q[MAX_TRACK].delete();
                        held_min = '0;
                        held_max = '0;
                    end
                    default: ;
                endcase
            end
            if (in_ch.valid && in_ch.ready)
            begin
                busy = 1'b1;
                want = predict_peaks(in_ch.in_sample);
                if (pin_active)
                    want = pin_peaks;
                expected_peaks.insert(expected_peaks.size(), want);
                samples_sent++;
            end
            if (out_ch.valid && out_ch.ready)
            begin
                busy = 1'b1;
                results_seen++;
                if (expected_peaks.size() == 0)
                    report_mismatch($sformatf("result %0d with nothing expected", results_seen));
                else
                begin
                    want = expected_peaks[0];
                    expected_peaks.delete(0);
                    if (out_ch.peak_min !== want.peak_min)
                        report_mismatch($sformatf("result %0d peak_min %0d, expected %0d",
                            results_seen, out_ch.peak_min, want.peak_min));
                    if (out_ch.peak_max !== want.peak_max)
                        report_mismatch($sformatf("result %0d peak_max %0d, expected %0d",
                            results_seen, out_ch.peak_max, want.peak_max));
                    if (out_ch.peak_updated !== want.peak_updated)
                        report_mismatch($sformatf("result %0d peak_updated %0b, expected %0b",
                            results_seen, out_ch.peak_updated, want.peak_updated));
                end
            end
            quiet_cycles = busy ? 0 : quiet_cycles + 1;
        end
    end

    // Receiver back-pressure
    initial
    begin
        out_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            out_ch.ready = !gaps_on || ($urandom_range(0, 99) >= 15);
        end
    end

    initial
    begin
        @(posedge rst_n);
        while (quiet_cycles < QUIET_LIMIT)
            @(negedge clk);
        $display("Timeout: no transfer for %0d cycles", QUIET_LIMIT);
        $display("FAILURE");
        $finish;
    end

    // Called at a falling edge; returns at the falling edge after the transfer.
    task automatic offer_sample(input logic signed [SAMPLE_BITS-1:0] s, input logic pin,
                                input peaks_t want);
        while (gaps_on && $urandom_range(0, 99) < 15)
        begin
            in_ch.valid = 1'b0;
            @(negedge clk);
        end
        in_ch.valid     = 1'b1;
        in_ch.in_sample = s;
        pin_active      = pin;
        pin_peaks       = want;
        do
            @(posedge clk);
        while (!in_ch.ready);
        @(negedge clk);
        pin_active = 1'b0;
    endtask

    task automatic drain_results();
        in_ch.valid = 1'b0;
        while (expected_peaks.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] index,
                                  input logic [CFG_DATA_W-1:0] data);
        drain_results();
        cfg_we    = 1'b1;
        cfg_index = index;
        cfg_data  = data;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic run_phase(input logic [CFG_DATA_W-1:0] factor_word,
                             input logic [CFG_DATA_W-1:0] window_word,
                             input int unsigned count, input bit with_gaps);
        write_register(CFG_DECIM, factor_word);
        write_register(CFG_WINDOW, window_word);
        gaps_on = with_gaps;
        repeat (count)
            offer_sample(next_sample(), 1'b0, '0);
    endtask

    initial
    begin
        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_index       = CFG_DECIM;
        cfg_data        = '0;
        in_ch.valid     = 1'b0;
        in_ch.in_sample = '0;
        repeat (11)
            @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (DIRECTED[i])
        begin
            if (DIRECTED[i].kind == ROW_WRITE)
                write_register(DIRECTED[i].reg_index, DIRECTED[i].data);
            else
                offer_sample(DIRECTED[i].sample, DIRECTED[i].pinned, DIRECTED[i].want);
        end

        run_phase(16'd1,   16'd100,   200, 1'b1);
        run_phase(16'd3,   16'd50000, 100, 1'b1);
        run_phase(16'd0,   16'hFFFF,  100, 1'b1);
        run_phase(16'd255, 16'd99,    120, 1'b1);
        run_phase(16'd2,   16'd150,   100, 1'b1);
        // every sample kept, no idle gaps and the receiver always ready
        run_phase(16'd1,   16'd300,   STEADY_ITEMS, 1'b0);
        run_phase(16'd44,  16'd5000,  40,  1'b1);

        drain_results();
        repeat (8)
            @(negedge clk);
        $display("Ran %0d samples, %0d kept into history, %0d register writes;",
                 samples_sent, kept_total, writes_done);
        $display("factor and window writes from zero to full scale, with and without idling.");
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// File: sim.f
+incdir+rtl
rtl/dsmm_pkg.sv
rtl/dsmm_if.sv
rtl/dsmm_deque.sv
rtl/decimated_sliding_min_max.sv
verif/decimated_sliding_min_max_test.sv
